@@ hdl/wsmib_pkg.sv @@
// shared types and constants for the window score mask interval builder
package wsmib_pkg;

   localparam int POS_W   = 32;
   localparam int SCORE_W = 16;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // result queue: room for two results per beat plus two in flight
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // register word indexes, taken from csr_paddr[2]
   localparam logic REG_EXTEND_LIMIT = 1'b0;
   localparam logic REG_MASK_CUTOFF  = 1'b1;

   typedef struct packed {
      logic [POS_W-1:0] open_first;
      logic [POS_W-1:0] open_final;
      logic [POS_W-1:0] cover_final;
   } run_state_type;

   typedef struct packed {
      logic [POS_W-1:0] mask_first;
      logic [POS_W-1:0] mask_final_pos;
      logic             run_done;
   } result_type;

   typedef struct packed {
      logic [1:0] num;
      result_type slot0;
      result_type slot1;
   } step_out_type;

endpackage

@@ hdl/wsmib_step.sv @@
// next-state and result logic for one scored window
module wsmib_step (
   input  logic [wsmib_pkg::SCORE_W-1:0] extend_limit,
   input  logic [wsmib_pkg::SCORE_W-1:0] mask_cutoff,
   input  wsmib_pkg::run_state_type      cur_state,
   input  logic [wsmib_pkg::SCORE_W-1:0] window_score,
   input  logic [wsmib_pkg::SCORE_W-1:0] trigger_value,
   input  logic [wsmib_pkg::POS_W-1:0]   window_first,
   input  logic [wsmib_pkg::POS_W-1:0]   window_last,
   input  logic                          final_window,
   output wsmib_pkg::run_state_type      nxt_state,
   output wsmib_pkg::step_out_type       step_out
);
   import wsmib_pkg::*;

   logic          is_open;
   logic          past_cover;
   logic          past_gap;
   logic          main_emit;
   result_type    main_res;
   run_state_type mid_state;
   logic          flush_emit;
   result_type    flush_res;

   assign is_open    = cur_state.open_final > cur_state.open_first;
   assign past_cover = window_first > cur_state.cover_final;
   // cover_final + 1 formed one bit wider so it never wraps
   assign past_gap   = {1'b0, window_first} > ({1'b0, cur_state.cover_final} + (POS_W+1)'(1));

   always_comb begin
      mid_state = cur_state;
      main_emit = 1'b0;
      main_res  = '{mask_first: cur_state.open_first,
                    mask_final_pos: cur_state.open_final,
                    run_done: 1'b0};
      priority if (window_score < extend_limit) begin
         if (is_open && past_cover) begin
            main_emit = 1'b1;
            mid_state = '0;
         end
      end else if (trigger_value < mask_cutoff) begin
         if (is_open) begin
            if (past_gap) begin
               main_emit = 1'b1;
               mid_state = '0;
            end else begin
               mid_state.cover_final = window_last;
            end
         end
      end else begin
         if (is_open) begin
            if (past_gap) begin
               main_emit            = 1'b1;
               mid_state.open_first = window_first;
            end
         end else begin
            mid_state.open_first = window_first;
         end
         mid_state.open_final  = window_last;
         mid_state.cover_final = window_last;
      end
   end

   always_comb begin
      flush_emit = final_window && (mid_state.open_final > mid_state.open_first);
      flush_res  = '{mask_first: mid_state.open_first,
                     mask_final_pos: mid_state.open_final,
                     run_done: 1'b1};
      nxt_state  = final_window ? run_state_type'('0) : mid_state;
   end

   always_comb begin
      step_out.num   = 2'(main_emit) + 2'(flush_emit);
      step_out.slot1 = flush_res;
      if (main_emit) begin
         step_out.slot0          = main_res;
         step_out.slot0.run_done = !flush_emit;
      end else begin
         step_out.slot0 = flush_res;
      end
   end

endmodule

@@ hdl/window_score_mask_interval_builder_core.sv @@
// top level: register port, run state and result queue of the mask interval builder
// Takes one scored window per req beat and emits the masked intervals it closes on the
// rsp channel; a window gives zero, one or two results, the last one marked by rsp_tlast.
// The run state is updated in the cycle the beat is taken, and each result is registered
// in a four-entry result queue before it shows on rsp. req_tready is high while at least
// two queue entries are free, so windows stream at one per cycle as long as rsp drains
// one result per cycle; a window that gives two results needs two rsp beats. extend_limit
// sits at byte address 0 and mask_cutoff at byte address 4; both reset to 0 and must be
// written only while the block is idle.
module window_score_mask_interval_builder_core (
   input  logic                         clock,
   input  logic                         reset,
   // window_score[15:0], trigger_value[31:16], window_first[63:32], window_last[95:64]
   input  logic [95:0]                  req_tdata,
   input  logic                         req_tlast,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // mask_first[31:0], mask_final_pos[63:32]
   output logic [63:0]                  rsp_tdata,
   output logic                         rsp_tlast,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [wsmib_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [wsmib_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [wsmib_pkg::CSR_DW-1:0] csr_prdata,
   output logic                         csr_pready
);
   import wsmib_pkg::*;

   logic [SCORE_W-1:0] extend_limit_ff, extend_limit_in;
   logic [SCORE_W-1:0] mask_cutoff_ff, mask_cutoff_in;
   run_state_type      state_ff, state_in;
   run_state_type      step_state;
   step_out_type       step_out;

   result_type         queue_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;

   logic               csr_write;
   logic               req_take;
   logic               rsp_take;
   result_type         head;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      extend_limit_in = extend_limit_ff;
      mask_cutoff_in  = mask_cutoff_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_EXTEND_LIMIT: extend_limit_in = csr_pwdata[SCORE_W-1:0];
            REG_MASK_CUTOFF:  mask_cutoff_in  = csr_pwdata[SCORE_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_EXTEND_LIMIT: csr_prdata = CSR_DW'(extend_limit_ff);
         REG_MASK_CUTOFF:  csr_prdata = CSR_DW'(mask_cutoff_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- window step ----------------
   wsmib_step u_step (
      .extend_limit  (extend_limit_ff),
      .mask_cutoff   (mask_cutoff_ff),
      .cur_state     (state_ff),
      .window_score  (req_tdata[15:0]),
      .trigger_value (req_tdata[31:16]),
      .window_first  (req_tdata[63:32]),
      .window_last   (req_tdata[95:64]),
      .final_window  (req_tlast),
      .nxt_state     (step_state),
      .step_out      (step_out)
   );

   assign req_tready = count_ff <= QCNT_W'(QDEPTH - 2);
   assign req_take   = req_tvalid && req_tready;
   assign state_in   = req_take ? step_state : state_ff;

   // ---------------- result queue ----------------
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {head.mask_final_pos, head.mask_first};
   assign rsp_tlast  = head.run_done;
   assign rsp_take   = rsp_tvalid && rsp_tready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(step_out.num);
         count_in  = count_in + QCNT_W'(step_out.num);
      end
      if (rsp_take) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
         count_in  = count_in - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         extend_limit_ff <= '0;
         mask_cutoff_ff  <= '0;
         state_ff        <= '0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
      end else begin
         extend_limit_ff <= extend_limit_in;
         mask_cutoff_ff  <= mask_cutoff_in;
         state_ff        <= state_in;
         wr_ptr_ff       <= wr_ptr_in;
         rd_ptr_ff       <= rd_ptr_in;
         count_ff        <= count_in;
      end
   end

   // payload entries, no reset needed
   always_ff @(posedge clock) begin
      if (req_take && step_out.num != 2'd0) begin
         queue_ff[wr_ptr_ff] <= step_out.slot0;
      end
      if (req_take && step_out.num == 2'd2) begin
         queue_ff[wr_ptr_ff + QPTR_W'(1)] <= step_out.slot1;
      end
   end

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("result queue overfilled");

   a_pair_queued: assert property (@(posedge clock) disable iff (reset)
      (req_take && step_out.num == 2'd2) |=> count_ff >= QCNT_W'(2))
      else $error("two results of one window not both queued");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_tlast) |=> (state_ff.open_final == '0 && state_ff.cover_final == '0))
      else $error("run state not cleared after final window");
`endif

endmodule
